>>> hdl/hphc_pkg.sv
package hphc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT        = 3'd0,
        CFG_HOLD_TICKS      = 3'd1,
        CFG_GAIN_P          = 3'd2,
        CFG_GAIN_I          = 3'd3,
        CFG_GAIN_D          = 3'd4,
        CFG_MAX_TEMPERATURE = 3'd5
    } cfg_idx_t;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic signed [16:0] MAX_TEMP_RESET = 17'sd28160;
    localparam logic signed [30:0] INTEG_LIMIT    = 31'sd256000000;
    localparam logic signed [32:0] DRIVE_MAX      = 33'sd400;
    localparam logic signed [32:0] DRIVE_MIN      = -33'sd300;
    localparam logic signed [17:0] ERR_NEAR       = 18'sd256;
    localparam logic signed [17:0] ERR_COOL_OFF   = -18'sd1280;
    localparam logic signed [17:0] ERR_FAN        = -18'sd768;
    localparam logic signed [18:0] DERIV_SLOW     = 19'sd26;
    localparam logic signed [16:0] SP_BOOST       = 17'sd23040;
    localparam logic signed [9:0]  DRIVE_FULL     = 10'sd400;

    typedef struct packed {
        logic signed [16:0] setpoint;
        logic [23:0]        hold_ticks;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic signed [16:0] max_temperature;
    } cfg_t;

    typedef struct packed {
        logic signed [29:0] integral_sum;
        logic signed [17:0] last_error;
        logic               reached;
        logic               done;
        logic [24:0]        hold_counter;
    } state_t;

    typedef struct packed {
        logic signed [9:0] drive;
        logic              fan_on;
        logic              at_temperature;
        logic              hold_finished;
    } result_t;

endpackage

>>> hdl/hphc_cfg.sv
module hphc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hphc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hphc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hphc_pkg::cfg_t                   cfg
);
    import hphc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SETPOINT:        cfg_next.setpoint        = $signed(cfg_data[16:0]);
                CFG_HOLD_TICKS:      cfg_next.hold_ticks      = cfg_data[23:0];
                CFG_GAIN_P:          cfg_next.gain_p          = cfg_data[15:0];
                CFG_GAIN_I:          cfg_next.gain_i          = cfg_data[15:0];
                CFG_GAIN_D:          cfg_next.gain_d          = cfg_data[15:0];
                CFG_MAX_TEMPERATURE: cfg_next.max_temperature = $signed(cfg_data[16:0]);
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{setpoint:        '0,
                         hold_ticks:      '0,
                         gain_p:          '0,
                         gain_i:          '0,
                         gain_d:          '0,
                         max_temperature: MAX_TEMP_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/hphc_calc.sv
module hphc_calc (
    input  hphc_pkg::cfg_t     cfg,
    input  hphc_pkg::state_t   st,
    input  logic               kind,
    input  logic signed [16:0] temperature,
    output hphc_pkg::state_t   st_next,
    output hphc_pkg::result_t  res
);
    import hphc_pkg::*;

    logic signed [17:0] err;
    logic signed [18:0] deriv;
    logic signed [30:0] integ_raw;
    logic signed [29:0] integ;
    logic signed [34:0] prod_p;
    logic signed [46:0] prod_i;
    logic signed [35:0] prod_d;
    logic signed [48:0] sum;
    logic signed [48:0] sum_adj;
    logic signed [32:0] quot;
    logic signed [9:0]  drive_pid;
    logic               reached_n;
    logic [24:0]        counter_n;
    logic               done_n;

    assign err       = 18'(cfg.setpoint) - 18'(temperature);
    assign deriv     = 19'(err) - 19'(st.last_error);
    assign integ_raw = 31'(st.integral_sum) + 31'(err);

    always_comb
    begin
        if (integ_raw > INTEG_LIMIT)
            integ = 30'(INTEG_LIMIT);
        else if (integ_raw < -INTEG_LIMIT)
            integ = 30'(-INTEG_LIMIT);
        else
            integ = 30'(integ_raw);
    end

    assign prod_p  = $signed({1'b0, cfg.gain_p}) * err;
    assign prod_i  = $signed({1'b0, cfg.gain_i}) * integ;
    assign prod_d  = $signed({1'b0, cfg.gain_d}) * deriv;
    assign sum     = 49'(prod_p) + 49'(prod_i) + 49'(prod_d);
    // round toward zero
    assign sum_adj = sum + (sum[48] ? 49'sd65535 : 49'sd0);
    assign quot    = 33'(sum_adj >>> 16);

    always_comb
    begin
        if (quot > DRIVE_MAX)
            drive_pid = 10'(DRIVE_MAX);
        else if (quot < DRIVE_MIN)
            drive_pid = 10'(DRIVE_MIN);
        else
            drive_pid = 10'(quot);
        // overrides, last one wins
        if (temperature > cfg.max_temperature)
            drive_pid = '0;
        if (err < ERR_COOL_OFF && deriv < DERIV_SLOW)
            drive_pid = '0;
        if (cfg.setpoint > SP_BOOST && err > ERR_NEAR)
            drive_pid = DRIVE_FULL;
    end

    always_comb
    begin
        reached_n = st.reached;
        counter_n = st.hold_counter;
        if (!st.reached && err > -ERR_NEAR && err < ERR_NEAR)
        begin
            reached_n = 1'b1;
            counter_n = '0;
        end
        else if (st.reached && counter_n != '1)
        begin
            counter_n = counter_n + 25'd1;
        end
        done_n = reached_n && (counter_n > 25'(cfg.hold_ticks));
    end

    always_comb
    begin
        if (kind == KIND_START)
        begin
            st_next = '0;
            res     = '0;
        end
        else if (st.done)
        begin
            st_next                = st;
            res.drive              = '0;
            res.fan_on             = 1'b0;
            res.at_temperature     = st.reached;
            res.hold_finished      = 1'b1;
        end
        else
        begin
            st_next.integral_sum   = integ;
            st_next.last_error     = err;
            st_next.reached        = reached_n;
            st_next.done           = done_n;
            st_next.hold_counter   = counter_n;
            res.drive              = done_n ? 10'sd0 : drive_pid;
            res.fan_on             = !done_n && (err < ERR_FAN);
            res.at_temperature     = reached_n;
            res.hold_finished      = done_n;
        end
    end

endmodule

>>> hdl/pid_heater_hold_controller.sv
// An accepted request waits in the input register until the result register can load its result.
// Throughput: one request per cycle while out_stall is low; the PID update is a single registered pass
// (input register, three multipliers and clamps, result register).
// Reset: asynchronous active low; clears run state, handshakes and config to defaults.
module pid_heater_hold_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic signed [16:0]               temperature,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [9:0]                drive,
    output logic                             fan_on,
    output logic                             at_temperature,
    output logic                             hold_finished,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hphc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hphc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hphc_pkg::*;

    cfg_t               cfg;
    state_t             st_reg;
    state_t             st_next;
    result_t            res;
    result_t            res_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_kind_reg;
    logic signed [16:0] s1_temp_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               s2_load;
    logic               in_accept;

    hphc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hphc_calc u_calc (
        .cfg         (cfg),
        .st          (st_reg),
        .kind        (s1_kind_reg),
        .temperature (s1_temp_reg),
        .st_next     (st_next),
        .res         (res)
    );

    assign s2_load   = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !s2_load;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;
        out_valid_next = s2_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_load)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_temp_reg <= temperature;
        end
        if (s2_load)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign drive          = res_reg.drive;
    assign fan_on         = res_reg.fan_on;
    assign at_temperature = res_reg.at_temperature;
    assign hold_finished  = res_reg.hold_finished;

`ifndef ASSERT_OFF
    a_finish_implies_reached: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_finished |-> at_temperature)
        else $error("hold finished without reaching temperature");

    a_finish_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_finished |-> drive == 10'sd0 && !fan_on)
        else $error("drive or fan active after hold finished");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive >= 10'(DRIVE_MIN) && drive <= DRIVE_FULL)
        else $error("drive out of range");

    a_state_frozen_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load && st_reg.done && s1_kind_reg == KIND_TICK |=> $stable(st_reg))
        else $error("run state changed after hold finished");
`endif

endmodule
